FILE: rtl/sgbu_pkg.sv
// ----------------------------------------------------------------------------
// sgbu_pkg
// Shared constants, types and state codes of the spatial grid bucket update
// core.
// ----------------------------------------------------------------------------
package sgbu_pkg;

  localparam int ZONES_PER_AXIS = 16;
  localparam int ZONE_BITS      = $clog2(ZONES_PER_AXIS);
  localparam int ZONE_ID_BITS   = 2 * ZONE_BITS;
  localparam int ZONE_CAPACITY  = 64;
  localparam int SLOT_BITS      = $clog2(ZONE_CAPACITY);
  localparam int COUNT_BITS     = SLOT_BITS + 1;
  localparam int PEOPLE         = 1024;
  localparam int PERSON_BITS    = $clog2(PEOPLE);
  localparam int POS_BITS       = 16;
  localparam int EXT_BITS       = 15;
  localparam int NZONES         = ZONES_PER_AXIS * ZONES_PER_AXIS;
  localparam int MEMBER_ADDR_BITS = ZONE_ID_BITS + SLOT_BITS;
  localparam int RECORD_BITS    = ZONE_ID_BITS + SLOT_BITS;

  localparam logic [EXT_BITS-1:0]   HALF_EXTENT_RESET = EXT_BITS'(1024);
  localparam logic [COUNT_BITS-1:0] CAPACITY_COUNT    = COUNT_BITS'(ZONE_CAPACITY);

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;
  localparam logic FUNC_PLACE  = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIN,
    ST_CNT,
    ST_CHK,
    ST_SWAP,
    ST_APPEND,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic                   status;
    logic [ZONE_BITS-1:0]   zone_x;
    logic [ZONE_BITS-1:0]   zone_y;
    logic [SLOT_BITS-1:0]   slot;
    logic                   changed;
    logic                   rel_valid;
    logic [PERSON_BITS-1:0] rel_person;
    logic [SLOT_BITS-1:0]   rel_slot;
  } result_t;

endpackage

FILE: rtl/spatial_grid_bucket_update_core.sv
// ----------------------------------------------------------------------------
// spatial_grid_bucket_update_core
// Uniform grid of zones with compact member lists; places and moves people.
// ----------------------------------------------------------------------------
// Sequence: the bit-serial binning divider, then the dependent count and
// member memory reads; a move with a swap rewrites the relocated member's
// slot before the append, and an item that changes nothing goes from the
// check straight to the output state.
// Flow: one item at a time; a held result does not block acceptance of the
// next item, but keeps that item's result in the output state.
// Reset: synchronous active-low; zones read empty, half_extent becomes 1024.
// ----------------------------------------------------------------------------
module spatial_grid_bucket_update_core
  import sgbu_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [EXT_BITS-1:0]        cfg_half_extent,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [PERSON_BITS-1:0]     in_person,
  input  logic signed [POS_BITS-1:0] in_pos_x,
  input  logic signed [POS_BITS-1:0] in_pos_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_status,
  output logic [ZONE_BITS-1:0]       out_zone_x,
  output logic [ZONE_BITS-1:0]       out_zone_y,
  output logic [SLOT_BITS-1:0]       out_slot,
  output logic                       out_changed,
  output logic                       out_relocated_valid,
  output logic [PERSON_BITS-1:0]     out_relocated_person,
  output logic [SLOT_BITS-1:0]       out_relocated_slot
);

  logic [EXT_BITS-1:0]  half_extent_r;
  logic                 accept;
  logic                 idle;
  logic                 done_x, done_y;
  logic [ZONE_BITS-1:0] zone_x, zone_y;
  logic                 res_valid;
  result_t              res;
  result_t              out_r;
  logic                 out_valid_r;

  assign in_stall = !idle;
  assign accept   = in_valid && idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_extent_r <= HALF_EXTENT_RESET;
    end else if (cfg_we) begin
      half_extent_r <= cfg_half_extent;
    end
  end

  sgbu_binner u_bin_x (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept),
    .pos         (in_pos_x),
    .half_extent (half_extent_r),
    .done        (done_x),
    .zone        (zone_x)
  );

  sgbu_binner u_bin_y (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept),
    .pos         (in_pos_y),
    .half_extent (half_extent_r),
    .done        (done_y),
    .zone        (zone_y)
  );

  sgbu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_func),
    .person    (in_person),
    .bin_done  (done_x && done_y),
    .zone_x    (zone_x),
    .zone_y    (zone_y),
    .res_ready (!out_valid_r || !out_stall),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_r.status;
  assign out_zone_x           = out_r.zone_x;
  assign out_zone_y           = out_r.zone_y;
  assign out_slot             = out_r.slot;
  assign out_changed          = out_r.changed;
  assign out_relocated_valid  = out_r.rel_valid;
  assign out_relocated_person = out_r.rel_person;
  assign out_relocated_slot   = out_r.rel_slot;

endmodule

FILE: rtl/sgbu_binner.sv
// ----------------------------------------------------------------------------
// sgbu_binner
// Bins one coordinate into a zone index: floor(t * ZONES / (2 * h)) with
// t = pos + h, by restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sgbu_binner
  import sgbu_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [POS_BITS-1:0] pos,
  input  logic [EXT_BITS-1:0]        half_extent,
  output logic                       done,
  output logic [ZONE_BITS-1:0]       zone
);

  localparam int T_BITS    = POS_BITS + 2;
  localparam int REM_BITS  = T_BITS + ZONE_BITS;
  localparam int STEP_BITS = (ZONE_BITS > 1) ? $clog2(ZONE_BITS) : 1;
  localparam logic [STEP_BITS-1:0] STEP_TOP = STEP_BITS'(ZONE_BITS - 1);

  logic [EXT_BITS-1:0]  h_eff;
  logic [T_BITS-1:0]    t_sum;
  logic                 t_le0;
  logic [REM_BITS-1:0]  rem_init;
  logic                 sat;
  logic [REM_BITS-1:0]  den_sh;

  logic [EXT_BITS-1:0]  h_r;
  logic [REM_BITS-1:0]  rem_r;
  logic [ZONE_BITS-1:0] q_r;
  logic                 zero_r;
  logic                 sat_r;
  logic [STEP_BITS-1:0] step_r;
  logic                 busy_r;
  logic                 done_r;

  always_comb begin
    h_eff    = (half_extent == '0) ? EXT_BITS'(1) : half_extent;
    t_sum    = {{(T_BITS-POS_BITS){pos[POS_BITS-1]}}, pos} +
               {{(T_BITS-EXT_BITS){1'b0}}, h_eff};
    t_le0    = t_sum[T_BITS-1] | (t_sum == '0);
    rem_init = REM_BITS'(t_sum[T_BITS-2:0]) << (ZONE_BITS - 1);
    sat      = rem_init >= (REM_BITS'(h_eff) << ZONE_BITS);
    den_sh   = REM_BITS'(h_r) << step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_TOP;
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      h_r    <= h_eff;
      rem_r  <= rem_init;
      q_r    <= '0;
      zero_r <= t_le0;
      sat_r  <= sat;
    end else if (busy_r && (rem_r >= den_sh)) begin
      rem_r          <= rem_r - den_sh;
      q_r[step_r]    <= 1'b1;
    end
  end

  assign done = done_r;
  assign zone = zero_r ? '0 : (sat_r ? '1 : q_r);

endmodule

FILE: rtl/sgbu_ctrl.sv
// ----------------------------------------------------------------------------
// sgbu_ctrl
// Sequencer and state memories: zone counts, zone member lists and the
// per-person zone and slot records, updated by read-modify-write.
// ----------------------------------------------------------------------------
module sgbu_ctrl
  import sgbu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   func,
  input  logic [PERSON_BITS-1:0] person,
  input  logic                   bin_done,
  input  logic [ZONE_BITS-1:0]   zone_x,
  input  logic [ZONE_BITS-1:0]   zone_y,
  input  logic                   res_ready,
  output logic                   idle,
  output logic                   res_valid,
  output result_t                res
);

  ctrl_state_t state_r, state_nxt;

  logic                   func_r;
  logic [PERSON_BITS-1:0] person_r;
  result_t                res_r, res_nxt;

  // Zone counts with one valid bit per zone; an unwritten zone reads as empty.
  logic [COUNT_BITS-1:0]  cnt_mem [NZONES];
  logic [NZONES-1:0]      cnt_vld_r;
  logic [COUNT_BITS-1:0]  cn_q_r, co_q_r;
  logic                   vn_r, vo_r;
  logic                   cnt_re, cnt_we;
  logic [ZONE_ID_BITS-1:0] cnt_waddr;
  logic [COUNT_BITS-1:0]  cnt_wdata;

  logic [PERSON_BITS-1:0] mem_mem [NZONES * ZONE_CAPACITY];
  logic [PERSON_BITS-1:0] mem_q_r;
  logic                   mem_re, mem_we;
  logic [MEMBER_ADDR_BITS-1:0] mem_raddr, mem_waddr;
  logic [PERSON_BITS-1:0] mem_wdata;

  logic [RECORD_BITS-1:0] pm_mem [PEOPLE];
  logic [RECORD_BITS-1:0] pm_q_r;
  logic                   pm_we;
  logic                   pm_zone_we;
  logic [PERSON_BITS-1:0] pm_waddr;
  logic [RECORD_BITS-1:0] pm_wdata;

  logic [ZONE_ID_BITS-1:0] nz, oz;
  logic [SLOT_BITS-1:0]    os;
  logic [COUNT_BITS-1:0]   cnt_n, cnt_o, last;

  always_comb begin
    nz    = {zone_x, zone_y};
    oz    = pm_q_r[RECORD_BITS-1:SLOT_BITS];
    os    = pm_q_r[SLOT_BITS-1:0];
    cnt_n = vn_r ? cn_q_r : '0;
    cnt_o = vo_r ? co_q_r : '0;
    last  = cnt_o - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= func;
      person_r <= person;
    end
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    res_nxt    = res_r;
    idle       = 1'b0;
    res_valid  = 1'b0;
    cnt_re     = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = oz;
    cnt_wdata  = last;
    mem_re     = 1'b0;
    mem_raddr  = {oz, last[SLOT_BITS-1:0]};
    mem_we     = 1'b0;
    mem_waddr  = {oz, os};
    mem_wdata  = mem_q_r;
    pm_we      = 1'b0;
    pm_zone_we = 1'b0;
    pm_waddr   = mem_q_r;
    pm_wdata   = {oz, os};
    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
        if (accept) begin
          state_nxt = ST_BIN;
        end
      end
      ST_BIN: begin
        if (bin_done) begin
          state_nxt = ST_CNT;
        end
      end
      ST_CNT: begin
        cnt_re    = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        res_nxt = '0;
        if (func_r == FUNC_PLACE) begin
          if (cnt_n >= CAPACITY_COUNT) begin
            res_nxt.status = STATUS_FULL;
            res_nxt.zone_x = zone_x;
            res_nxt.zone_y = zone_y;
            state_nxt      = ST_OUT;
          end else begin
            state_nxt = ST_APPEND;
          end
        end else if ((oz == nz) || (cnt_n >= CAPACITY_COUNT)) begin
          res_nxt.status = (oz == nz) ? STATUS_OK : STATUS_FULL;
          res_nxt.zone_x = oz[ZONE_ID_BITS-1:ZONE_BITS];
          res_nxt.zone_y = oz[ZONE_BITS-1:0];
          res_nxt.slot   = os;
          state_nxt      = ST_OUT;
        end else begin
          state_nxt = ST_APPEND;
          if (cnt_o != '0) begin
            // The leaver's list shrinks by one; a leaver not at the end
            // first gets the last member moved into its slot.
            cnt_we = 1'b1;
            if ({1'b0, os} < last) begin
              mem_re    = 1'b1;
              state_nxt = ST_SWAP;
            end
          end
        end
      end
      ST_SWAP: begin
        // Only the slot of the relocated member is rewritten; its zone
        // record stays as it is, even when it names another zone.
        mem_we             = 1'b1;
        pm_we              = 1'b1;
        res_nxt.rel_valid  = 1'b1;
        res_nxt.rel_person = mem_q_r;
        res_nxt.rel_slot   = os;
        state_nxt          = ST_APPEND;
      end
      ST_APPEND: begin
        mem_we         = 1'b1;
        mem_waddr      = {nz, cnt_n[SLOT_BITS-1:0]};
        mem_wdata      = person_r;
        cnt_we         = 1'b1;
        cnt_waddr      = nz;
        cnt_wdata      = cnt_n + 1'b1;
        pm_we          = 1'b1;
        pm_zone_we     = 1'b1;
        pm_waddr       = person_r;
        pm_wdata       = {nz, cnt_n[SLOT_BITS-1:0]};
        res_nxt.status = STATUS_OK;
        res_nxt.zone_x = zone_x;
        res_nxt.zone_y = zone_y;
        res_nxt.slot   = cnt_n[SLOT_BITS-1:0];
        res_nxt.changed = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (cnt_we) begin
      cnt_vld_r[cnt_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cn_q_r <= cnt_mem[nz];
      co_q_r <= cnt_mem[oz];
      vn_r   <= cnt_vld_r[nz];
      vo_r   <= cnt_vld_r[oz];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm_mem[pm_waddr][SLOT_BITS-1:0] <= pm_wdata[SLOT_BITS-1:0];
      if (pm_zone_we) begin
        pm_mem[pm_waddr][RECORD_BITS-1:SLOT_BITS] <= pm_wdata[RECORD_BITS-1:SLOT_BITS];
      end
    end
    if (accept) begin
      pm_q_r <= pm_mem[person];
    end
  end

  assign res = res_r;

endmodule

FILE: rtl/sgbu_checker.sv
// ----------------------------------------------------------------------------
// sgbu_checker
// Port-level checks of the spatial grid bucket update core.
// ----------------------------------------------------------------------------
module sgbu_checker
  import sgbu_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   out_status,
  input logic                   out_changed,
  input logic                   out_relocated_valid,
  input logic [PERSON_BITS-1:0] out_relocated_person,
  input logic [SLOT_BITS-1:0]   out_relocated_slot
);

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_relocated_person) &&
    $stable(out_status) && $stable(out_relocated_slot))
    else $error("stalled result item changed");

  // One item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");

  // A refused item changes nothing.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_changed && !out_relocated_valid)
    else $error("refused item reports a change");

  // Relocation fields are zero without a relocation.
  a_rel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_relocated_valid |->
    out_relocated_person == '0 && out_relocated_slot == '0)
    else $error("relocation fields set without relocation");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind spatial_grid_bucket_update_core sgbu_checker u_sgbu_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_status           (out_status),
  .out_changed          (out_changed),
  .out_relocated_valid  (out_relocated_valid),
  .out_relocated_person (out_relocated_person),
  .out_relocated_slot   (out_relocated_slot)
);
